/* hdl/fanpwm_pkg.sv */
package fanpwm_pkg;

	// sensor word width
	localparam int AdcBits  = 10;
	// ramp numerator |temp - min| * 255 needs eight more bits
	localparam int NumW     = AdcBits + 8;
	localparam int DivCntW  = $clog2(NumW);

	localparam logic [7:0] DutyMax      = 8'hff;
	localparam logic [7:0] LowDutyLimit = 8'd10;

	// configuration register indexes
	localparam logic [2:0] CfgMinTemp   = 3'd0;
	localparam logic [2:0] CfgMaxTemp   = 3'd1;
	localparam logic [2:0] CfgStartTemp = 3'd2;
	localparam logic [2:0] CfgMinDuty   = 3'd3;
	localparam logic [2:0] CfgDualSens  = 3'd4;

	// command codes
	localparam logic CmdSample = 1'b0;
	localparam logic CmdTick   = 1'b1;

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_PWM  = 2'd1,
		MODE_FULL = 2'd2
	} fan_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK,
		ST_CTRL,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic                 start;
		logic [NumW-1:0]      num;
		logic [AdcBits-1:0]   den;
	} div_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] quo;
	} div_rsp_t;

endpackage

/* hdl/fan_temperature_pwm_controller.sv */
// Temperature controlled fan driver. Each input beat is either an ADC sample for
// sensor channel 0 or 1 (cmd 0) or one prescaled timer tick (cmd 1); every beat
// returns exactly one result beat with the fan pin level, the fan mode (off, pwm,
// full) and the current duty. Samples move the mode between off, pwm and full
// using start, minimum and maximum thresholds with hysteresis; in pwm mode the
// duty is (temp - min) * 255 / (max - min), saturated to 0..255 and raised to
// min_duty. Ticks step an 8-bit timer whose overflow toggles the pin in pwm mode,
// except that a low pin stays low while duty is at most LowDutyLimit. One item
// at a time: a tick, or a sample leaving the fan off or at full speed, goes through
// ST_TICK or ST_CTRL to ST_DONE; a pwm sample whose duty needs no division (zero
// range, or a ramp at or below zero) also passes ST_PREP, and one that needs the
// restoring divider waits in ST_DIV for one quotient bit per cycle over an 18-bit
// numerator. A new beat is taken while the previous result still waits in the
// output register. Configuration is written through cfg_we/cfg_index/cfg_data
// by the user only while idle; the block itself does not enforce this.
module fan_temperature_pwm_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [fanpwm_pkg::AdcBits-1:0] cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic                          channel,
	input  logic [fanpwm_pkg::AdcBits-1:0] sample,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          fan_on,
	output logic [1:0]                    mode,
	output logic [7:0]                    duty_now
);
	import fanpwm_pkg::*;

	// configuration registers
	logic [AdcBits-1:0] min_temp_q, max_temp_q, start_temp_q;
	logic [7:0]         min_duty_q;
	logic               dual_q;

	// controller state
	seq_state_t         st_q, st_nx;
	fan_mode_t          mode_q, mode_nx;
	logic               pin_q, pin_nx;
	logic [7:0]         duty_q;
	logic [7:0]         timer_q;
	logic [AdcBits-1:0] samp0_q, samp1_q, temp_q;

	// result register
	logic               out_valid_q;
	logic               fan_on_q;
	logic [1:0]         mode_out_q;
	logic [7:0]         duty_out_q;

	// sequencer controls
	logic in_take, div_start, out_load;
	logic in_acc, out_free;

	div_req_t req;
	div_rsp_t rsp;

	// control temperature, mode transitions
	logic [AdcBits-1:0] temp_c;

	// duty preparation
	logic [AdcBits:0]   diff_c, range_c;
	logic [AdcBits-1:0] diff_abs, range_abs;
	logic               prep_div;
	logic [7:0]         prep_duty;

	// timer
	logic [7:0]         tmr_inc;

	logic [7:0]         div_duty;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	//------------------------------------------------------------------
	// configuration writes
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_temp_q   <= AdcBits'(300);
			max_temp_q   <= AdcBits'(600);
			start_temp_q <= AdcBits'(350);
			min_duty_q   <= 8'd40;
			dual_q       <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgMinTemp:   min_temp_q   <= cfg_data;
				CfgMaxTemp:   max_temp_q   <= cfg_data;
				CfgStartTemp: start_temp_q <= cfg_data;
				CfgMinDuty:   min_duty_q   <= cfg_data[7:0];
				CfgDualSens:  dual_q       <= cfg_data[0];
				default:      ;
			endcase
		end
	end

	//------------------------------------------------------------------
	// mode decision: first matching rule wins
	//------------------------------------------------------------------
	always_comb begin
		temp_c = samp0_q;
		if (dual_q && (samp1_q > samp0_q))
			temp_c = samp1_q;

		mode_nx = mode_q;
		pin_nx  = pin_q;
		if (mode_q == MODE_OFF && temp_c >= start_temp_q) begin
			mode_nx = MODE_PWM;
		end else if (mode_q == MODE_PWM && temp_c >= max_temp_q) begin
			mode_nx = MODE_FULL;
			pin_nx  = 1'b1;
		end else if (mode_q == MODE_FULL && temp_c < max_temp_q) begin
			mode_nx = MODE_PWM;
		end else if (mode_q != MODE_OFF && temp_c < min_temp_q) begin
			mode_nx = MODE_OFF;
			pin_nx  = 1'b0;
		end
	end

	//------------------------------------------------------------------
	// duty set-up. Opposite signs or a zero numerator give min_duty,
	// zero range saturates; only same-sign cases reach the divider,
	// which then works on magnitudes.
	//------------------------------------------------------------------
	always_comb begin
		diff_c    = {1'b0, temp_q} - {1'b0, min_temp_q};
		range_c   = {1'b0, max_temp_q} - {1'b0, min_temp_q};
		diff_abs  = diff_c[AdcBits]  ? AdcBits'(-diff_c)  : diff_c[AdcBits-1:0];
		range_abs = range_c[AdcBits] ? AdcBits'(-range_c) : range_c[AdcBits-1:0];
		prep_div  = 1'b0;
		prep_duty = min_duty_q;
		if (range_c == '0) begin
			prep_duty = DutyMax;
		end else if (diff_c != '0 && diff_c[AdcBits] == range_c[AdcBits]) begin
			prep_div = 1'b1;
		end
		req.start = div_start;
		req.num   = {diff_abs, 8'd0} - NumW'(diff_abs);   // x * 255
		req.den   = range_abs;
	end

	fanpwm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign div_duty = (rsp.quo < min_duty_q) ? min_duty_q : rsp.quo;
	assign tmr_inc  = timer_q + 8'd1;

	//------------------------------------------------------------------
	// sequencer
	//------------------------------------------------------------------
	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			ST_IDLE: if (in_acc) st_nx = (cmd == CmdTick) ? ST_TICK : ST_CTRL;
			ST_TICK: st_nx = ST_DONE;
			ST_CTRL: st_nx = (mode_nx == MODE_PWM) ? ST_PREP : ST_DONE;
			ST_PREP: st_nx = prep_div ? ST_DIV : ST_DONE;
			ST_DIV:  if (rsp.done) st_nx = ST_DONE;
			ST_DONE: if (out_free) st_nx = ST_IDLE;
			default: st_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		in_take   = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (st_q)
			ST_IDLE: in_take   = 1'b1;
			ST_PREP: div_start = prep_div;
			ST_DONE: out_load  = out_free;
			default: ;
		endcase
	end

	assign in_stall = !in_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			mode_q  <= MODE_OFF;
			pin_q   <= 1'b0;
			duty_q  <= '0;
			timer_q <= '0;
			samp0_q <= '0;
			samp1_q <= '0;
		end else begin
			st_q <= st_nx;
			if (in_acc && cmd == CmdSample) begin
				if (channel) samp1_q <= sample;
				else         samp0_q <= sample;
			end
			unique case (st_q)
				ST_TICK: begin
					// overflow in pwm mode reloads the timer and flips the pin, unless the pin is low and duty is at most LowDutyLimit
					if (tmr_inc != 8'd0 || mode_q != MODE_PWM) begin
						timer_q <= tmr_inc;
					end else if (pin_q) begin
						timer_q <= duty_q;
						pin_q   <= 1'b0;
					end else if (duty_q > LowDutyLimit) begin
						timer_q <= ~duty_q;
						pin_q   <= 1'b1;
					end else begin
						timer_q <= tmr_inc;
					end
				end
				ST_CTRL: begin
					mode_q <= mode_nx;
					pin_q  <= pin_nx;
				end
				ST_PREP: if (!prep_div) duty_q <= prep_duty;
				ST_DIV:  if (rsp.done) duty_q <= div_duty;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_CTRL)
			temp_q <= temp_c;
	end

	//------------------------------------------------------------------
	// result register
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			fan_on_q   <= pin_q;
			mode_out_q <= mode_q;
			duty_out_q <= duty_q;
		end
	end

	assign out_valid = out_valid_q;
	assign fan_on    = fan_on_q;
	assign mode      = mode_out_q;
	assign duty_now  = duty_out_q;

endmodule

/* hdl/fanpwm_div.sv */
module fanpwm_div (
	input  logic                clk,
	input  logic                arst_n,
	input  fanpwm_pkg::div_req_t req,
	output fanpwm_pkg::div_rsp_t rsp
);
	import fanpwm_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DivCntW-1:0]   cnt_q;
	logic [AdcBits-1:0]   den_q;
	logic [AdcBits-1:0]   rem_q;
	logic [NumW-1:0]      quo_q;

	logic [AdcBits:0]     shifted;
	logic                 ge;
	logic [AdcBits:0]     diff;
	logic [AdcBits-1:0]   rem_nx;

	// restoring divide, one quotient bit per cycle
	always_comb begin
		shifted = {rem_q, quo_q[NumW-1]};
		ge      = (shifted >= {1'b0, den_q});
		diff    = shifted - {1'b0, den_q};
		rem_nx  = ge ? diff[AdcBits-1:0] : shifted[AdcBits-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DivCntW'(NumW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= req.num;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[NumW-2:0], ge};
		end
	end

	// quotient above 255 saturates
	always_comb begin
		rsp.done = done_q;
		rsp.quo  = (quo_q[NumW-1:8] != '0) ? DutyMax : quo_q[7:0];
	end

endmodule
